>>> sv/bll_pkg.sv
`default_nettype none
package bll_pkg;

  localparam int NODES   = 1024;
  localparam int LEVELS  = 11;
  localparam int NODE_W  = $clog2(NODES);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int DEPTH_W = 11;
  localparam int JDEPTH  = NODES * LEVELS;
  localparam int JADDR_W = $clog2(JDEPTH);

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Requests to the ancestor table: one write port, two read ports.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] wnode;
    logic [LVL_W-1:0]  wlvl;
    logic [NODE_W-1:0] wdata;
    logic [NODE_W-1:0] anode;
    logic [LVL_W-1:0]  alvl;
    logic [NODE_W-1:0] bnode;
    logic [LVL_W-1:0]  blvl;
  } jmp_req_t;

  // Requests to the depth store: one write port, two read ports.
  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
    logic [NODE_W-1:0]  aaddr;
    logic [NODE_W-1:0]  baddr;
  } dep_req_t;

endpackage
`default_nettype wire

>>> sv/bll_depth_mem.sv
`default_nettype none
module bll_depth_mem (
  input  wire logic                        clk,
  input  wire bll_pkg::dep_req_t           req,
  output logic [bll_pkg::DEPTH_W-1:0]      da,
  output logic [bll_pkg::DEPTH_W-1:0]      db
);

  logic [bll_pkg::DEPTH_W-1:0] mem [bll_pkg::NODES];
  logic [bll_pkg::DEPTH_W-1:0] qa_r;
  logic [bll_pkg::DEPTH_W-1:0] qb_r;
  logic                        za_r;
  logic                        zb_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Node 0 sits above the root and is never written: it always reads as depth 0.
  always_ff @(posedge clk) begin
    qa_r <= mem[req.aaddr];
    qb_r <= mem[req.baddr];
    za_r <= (req.aaddr == '0);
    zb_r <= (req.baddr == '0);
  end

  assign da = za_r ? '0 : qa_r;
  assign db = zb_r ? '0 : qb_r;

endmodule
`default_nettype wire

>>> sv/bll_jump_mem.sv
`default_nettype none
module bll_jump_mem (
  input  wire logic                       clk,
  input  wire bll_pkg::jmp_req_t          req,
  output logic [bll_pkg::NODE_W-1:0]      ja,
  output logic [bll_pkg::NODE_W-1:0]      jb
);

  logic [bll_pkg::NODE_W-1:0]  mem [bll_pkg::JDEPTH];
  logic [bll_pkg::JADDR_W-1:0] waddr;
  logic [bll_pkg::JADDR_W-1:0] aaddr;
  logic [bll_pkg::JADDR_W-1:0] baddr;
  logic [bll_pkg::NODE_W-1:0]  qa_r;
  logic [bll_pkg::NODE_W-1:0]  qb_r;
  logic                        za_r;
  logic                        zb_r;
  logic                        fa_r;
  logic                        fb_r;
  logic [bll_pkg::NODE_W-1:0]  fd_r;

  assign waddr = bll_pkg::JADDR_W'(req.wnode) * bll_pkg::JADDR_W'(bll_pkg::LEVELS)
               + bll_pkg::JADDR_W'(req.wlvl);
  assign aaddr = bll_pkg::JADDR_W'(req.anode) * bll_pkg::JADDR_W'(bll_pkg::LEVELS)
               + bll_pkg::JADDR_W'(req.alvl);
  assign baddr = bll_pkg::JADDR_W'(req.bnode) * bll_pkg::JADDR_W'(bll_pkg::LEVELS)
               + bll_pkg::JADDR_W'(req.blvl);

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= req.wdata;
    end
  end

  // A read of the entry being written in the same cycle returns the new value.
  always_ff @(posedge clk) begin
    qa_r <= mem[aaddr];
    qb_r <= mem[baddr];
    za_r <= (req.anode == '0);
    zb_r <= (req.bnode == '0);
    fa_r <= req.we && (waddr == aaddr);
    fb_r <= req.we && (waddr == baddr);
    fd_r <= req.wdata;
  end

  // Every jump from the sentinel node stays at the sentinel.
  assign ja = za_r ? '0 : (fa_r ? fd_r : qa_r);
  assign jb = zb_r ? '0 : (fb_r ? fd_r : qb_r);

endmodule
`default_nettype wire

>>> sv/bll_ctrl.sv
`default_nettype none
module bll_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire bll_pkg::action_t            in_action,
  input  wire logic [bll_pkg::NODE_W-1:0]  in_node,
  input  wire logic [bll_pkg::NODE_W-1:0]  in_other,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [bll_pkg::NODE_W-1:0]       out_anc,
  output logic [bll_pkg::DEPTH_W-1:0]      out_dist,
  output bll_pkg::jmp_req_t                jreq,
  output bll_pkg::dep_req_t                dreq,
  input  wire logic [bll_pkg::NODE_W-1:0]  ja,
  input  wire logic [bll_pkg::NODE_W-1:0]  jb,
  input  wire logic [bll_pkg::DEPTH_W-1:0] da,
  input  wire logic [bll_pkg::DEPTH_W-1:0] db
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ADD  = 9'b000000010,
    S_QDEP = 9'b000000100,
    S_LIFT = 9'b000001000,
    S_CMP  = 9'b000010000,
    S_BOTH = 9'b000100000,
    S_ANC  = 9'b001000000,
    S_DIST = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  localparam logic [bll_pkg::LVL_W-1:0] LVL_TOP = bll_pkg::LVL_W'(bll_pkg::LEVELS - 1);

  state_t                      state_r, state_nxt;
  logic [bll_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [bll_pkg::NODE_W-1:0]  v_r, v_nxt;
  logic [bll_pkg::NODE_W-1:0]  x_r, x_nxt;
  logic [bll_pkg::NODE_W-1:0]  y_r, y_nxt;
  logic                        xp_r, xp_nxt;
  logic [bll_pkg::DEPTH_W-1:0] dx_r, dx_nxt;
  logic [bll_pkg::DEPTH_W-1:0] dy_r, dy_nxt;
  logic [bll_pkg::LEVELS-1:0]  gap_r, gap_nxt;
  logic [bll_pkg::NODE_W-1:0]  anc_r, anc_nxt;
  logic [bll_pkg::DEPTH_W-1:0] dist_r, dist_nxt;
  logic                        ov_r, ov_nxt;
  logic [bll_pkg::NODE_W-1:0]  oa_r, oa_nxt;
  logic [bll_pkg::DEPTH_W-1:0] od_r, od_nxt;

  logic [bll_pkg::NODE_W-1:0]  x_cur;
  logic [bll_pkg::NODE_W-1:0]  xn;
  logic [bll_pkg::NODE_W-1:0]  yn;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_anc    = oa_r;
  assign out_dist   = od_r;

  // While lifting, a jump issued last cycle replaces x when its data returns.
  assign x_cur = xp_r ? ja : x_r;
  assign xn    = (ja != jb) ? ja : x_r;
  assign yn    = (ja != jb) ? jb : y_r;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    v_nxt     = v_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    xp_nxt    = xp_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    gap_nxt   = gap_r;
    anc_nxt   = anc_r;
    dist_nxt  = dist_r;
    ov_nxt    = ov_r;
    oa_nxt    = oa_r;
    od_nxt    = od_r;
    jreq      = '0;
    dreq      = '0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_action == bll_pkg::ACT_ADD) begin
            if (in_node != '0) begin
              v_nxt      = in_node;
              dreq.aaddr = in_other;
              jreq.we    = 1'b1;
              jreq.wnode = in_node;
              jreq.wlvl  = '0;
              jreq.wdata = in_other;
              jreq.anode = in_other;
              jreq.alvl  = '0;
              lvl_nxt    = bll_pkg::LVL_W'(1);
              state_nxt  = S_ADD;
            end
          end else begin
            dreq.aaddr = in_node;
            dreq.baddr = in_other;
            x_nxt      = in_node;
            y_nxt      = in_other;
            state_nxt  = S_QDEP;
          end
        end
      end
      S_ADD: begin
        if (lvl_r == bll_pkg::LVL_W'(1)) begin
          dreq.we    = 1'b1;
          dreq.waddr = v_r;
          dreq.wdata = (da == '1) ? da : da + bll_pkg::DEPTH_W'(1);
        end
        jreq.we    = 1'b1;
        jreq.wnode = v_r;
        jreq.wlvl  = lvl_r;
        jreq.wdata = ja;
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          jreq.anode = ja;
          jreq.alvl  = lvl_r;
          lvl_nxt    = lvl_r + bll_pkg::LVL_W'(1);
        end
      end
      S_QDEP: begin
        dx_nxt = da;
        dy_nxt = db;
        if (da < db) begin
          x_nxt   = y_r;
          y_nxt   = x_r;
          gap_nxt = bll_pkg::LEVELS'(db - da);
        end else begin
          gap_nxt = bll_pkg::LEVELS'(da - db);
        end
        xp_nxt    = 1'b0;
        lvl_nxt   = LVL_TOP;
        state_nxt = S_LIFT;
      end
      S_LIFT: begin
        x_nxt  = x_cur;
        xp_nxt = gap_r[lvl_r];
        if (gap_r[lvl_r]) begin
          jreq.anode = x_cur;
          jreq.alvl  = lvl_r;
        end
        if (lvl_r == '0) begin
          state_nxt = S_CMP;
        end else begin
          lvl_nxt = lvl_r - bll_pkg::LVL_W'(1);
        end
      end
      S_CMP: begin
        x_nxt  = x_cur;
        xp_nxt = 1'b0;
        if (x_cur == y_r) begin
          anc_nxt    = x_cur;
          dreq.aaddr = x_cur;
          state_nxt  = S_DIST;
        end else begin
          jreq.anode = x_cur;
          jreq.alvl  = LVL_TOP;
          jreq.bnode = y_r;
          jreq.blvl  = LVL_TOP;
          lvl_nxt    = LVL_TOP;
          state_nxt  = S_BOTH;
        end
      end
      S_BOTH: begin
        x_nxt = xn;
        y_nxt = yn;
        if (lvl_r == '0) begin
          jreq.anode = xn;
          jreq.alvl  = '0;
          state_nxt  = S_ANC;
        end else begin
          jreq.anode = xn;
          jreq.alvl  = lvl_r - bll_pkg::LVL_W'(1);
          jreq.bnode = yn;
          jreq.blvl  = lvl_r - bll_pkg::LVL_W'(1);
          lvl_nxt    = lvl_r - bll_pkg::LVL_W'(1);
        end
      end
      S_ANC: begin
        anc_nxt    = ja;
        dreq.aaddr = ja;
        state_nxt  = S_DIST;
      end
      S_DIST: begin
        dist_nxt  = dx_r + dy_r - {da[bll_pkg::DEPTH_W-2:0], 1'b0};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          oa_nxt    = anc_r;
          od_nxt    = dist_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      xp_r    <= 1'b0;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      xp_r    <= xp_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    gap_r  <= gap_nxt;
    anc_r  <= anc_nxt;
    dist_r <= dist_nxt;
    oa_r   <= oa_nxt;
    od_r   <= od_nxt;
  end

endmodule
`default_nettype wire

>>> sv/binary_lifting_lca.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// in_       input      in_tvalid/in_tready   tuser: action; tdata: node, other_node
// out_      output     out_tvalid/out_tready tdata: ancestor, distance
//
// An add makes one ancestor-table write per level, and a read at each but the top.
// A query is shorter when the lifted node meets the other; its length is set
// by the chain of dependent ancestor-table reads.
// Reset clears only control; node 0 reads as depth 0 and jumps to itself, so
// there is no clearing pass. A new item is taken while a result waits, and
// a stalled result holds only the next query at its last step.
module binary_lifting_lca (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [0:0]  in_tuser,   // [0] action
  input  wire logic [23:0] in_tdata,   // [9:0] node, [19:10] other_node, [23:20] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [9:0] ancestor, [20:10] distance, [23:21] zero
);

  bll_pkg::jmp_req_t            jreq;
  bll_pkg::dep_req_t            dreq;
  logic [bll_pkg::NODE_W-1:0]   ja;
  logic [bll_pkg::NODE_W-1:0]   jb;
  logic [bll_pkg::DEPTH_W-1:0]  da;
  logic [bll_pkg::DEPTH_W-1:0]  db;
  logic [bll_pkg::NODE_W-1:0]   out_anc;
  logic [bll_pkg::DEPTH_W-1:0]  out_dist;
  bll_pkg::action_t             in_action;

  assign in_action = bll_pkg::action_t'(in_tuser[0]);
  assign out_tdata = {3'b000, out_dist, out_anc};

  bll_depth_mem u_depth (
    .clk (clk),
    .req (dreq),
    .da  (da),
    .db  (db)
  );

  bll_jump_mem u_jump (
    .clk (clk),
    .req (jreq),
    .ja  (ja),
    .jb  (jb)
  );

  bll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_action),
    .in_node    (in_tdata[9:0]),
    .in_other   (in_tdata[19:10]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_anc    (out_anc),
    .out_dist   (out_dist),
    .jreq       (jreq),
    .dreq       (dreq),
    .ja         (ja),
    .jb         (jb),
    .da         (da),
    .db         (db)
  );

  // The sentinel node is never written.
  a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
    jreq.we |-> (jreq.wnode != '0))
    else $error("ancestor table write to sentinel node");

  // A depth write always goes with a table write for the same node.
  a_depth_with_jump: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.we |-> (jreq.we && (jreq.wnode == dreq.waddr) && (jreq.wlvl == 4'd1)))
    else $error("depth write without matching table write");

  // Table writes stay inside the levels of the node.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    jreq.we |-> (jreq.wlvl < 4'(bll_pkg::LEVELS)))
    else $error("table write level out of range");

  // An accepted query keeps the input closed on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_action == bll_pkg::ACT_QUERY)) |=> !in_tready)
    else $error("input open right after a query was taken");

endmodule
`default_nettype wire
